>>> hw/rtl/fnrs_pkg.sv
// Shared constants and types for the fixed-radius neighbor search block.
`default_nettype none

package fnrs_pkg;

    localparam int MAX_AGENTS_DEF  = 32;
    localparam int COORD_BITS_DEF  = 24;

    localparam int ID_W   = 5;
    localparam int CFG_W  = 6;
    localparam int POS_W  = 24;
    localparam int RAD_W  = 23;
    localparam int R2_W   = 2 * RAD_W;

    localparam logic [CFG_W-1:0] CFG_RESET_AGENTS = 6'd32;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Tag that travels with one table entry through the distance pipeline
    typedef struct packed {
        logic            vld;
        logic            skip;
        logic [ID_W-1:0] id;
    } t_tag;

    // Compare result at the end of the distance pipeline
    typedef struct packed {
        logic            vld;
        logic            hit;
        logic [ID_W-1:0] id;
    } t_hit;

endpackage

`default_nettype wire

>>> hw/rtl/fnrs_table.sv
// Position table: one synchronous memory with per-entry valid bits and a registered read port.
`default_nettype none

module fnrs_table
    import fnrs_pkg::*;
#(
    parameter int MAX_AGENTS = MAX_AGENTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_wr_en,
    input  wire logic [$clog2(MAX_AGENTS)-1:0] i_wr_addr,
    input  wire logic [COORD_BITS-1:0]         i_wr_x,
    input  wire logic [COORD_BITS-1:0]         i_wr_y,
    input  wire logic                          i_rd_en,
    input  wire logic [$clog2(MAX_AGENTS)-1:0] i_rd_addr,
    output logic      [COORD_BITS-1:0]         o_rd_x,
    output logic      [COORD_BITS-1:0]         o_rd_y
);

    logic [2*COORD_BITS-1:0] r_mem [MAX_AGENTS];
    logic [MAX_AGENTS-1:0]   r_vld;
    logic [2*COORD_BITS-1:0] r_rd_q;
    logic                    r_rd_v;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_x, i_wr_y};
        end
        if (i_rd_en) begin
            r_rd_q <= r_mem[i_rd_addr];
        end
    end

    // An entry never written reads as the reset position, the origin
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rd_v <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_v <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_x = r_rd_v ? r_rd_q[2*COORD_BITS-1:COORD_BITS] : '0;
    assign o_rd_y = r_rd_v ? r_rd_q[COORD_BITS-1:0] : '0;

endmodule

`default_nettype wire

>>> hw/rtl/fnrs_dist.sv
// Distance pipeline: absolute differences, squares, then compare against the squared radius.
`default_nettype none

module fnrs_dist
    import fnrs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire t_tag                  i_tag,
    input  wire logic [COORD_BITS-1:0] i_rd_x,
    input  wire logic [COORD_BITS-1:0] i_rd_y,
    input  wire logic [COORD_BITS-1:0] i_self_x,
    input  wire logic [COORD_BITS-1:0] i_self_y,
    input  wire logic [R2_W-1:0]       i_r2,
    output t_hit                       o_hit,
    output logic                       o_busy
);

    localparam int SQ_W = 2 * COORD_BITS;
    localparam int SW   = (SQ_W + 1 > R2_W) ? SQ_W + 1 : R2_W;

    logic signed [COORD_BITS:0] w_dx;
    logic signed [COORD_BITS:0] w_dy;
    logic [COORD_BITS-1:0]      w_adx;
    logic [COORD_BITS-1:0]      w_ady;
    logic [SW-1:0]              w_sum;

    t_tag                  r_c_tag;
    logic [COORD_BITS-1:0] r_c_dx;
    logic [COORD_BITS-1:0] r_c_dy;
    t_tag                  r_d_tag;
    logic [SQ_W-1:0]       r_d_dx2;
    logic [SQ_W-1:0]       r_d_dy2;

    // Difference of two signed coordinates; its magnitude fits COORD_BITS bits
    assign w_dx  = $signed({i_rd_x[COORD_BITS-1], i_rd_x})
                 - $signed({i_self_x[COORD_BITS-1], i_self_x});
    assign w_dy  = $signed({i_rd_y[COORD_BITS-1], i_rd_y})
                 - $signed({i_self_y[COORD_BITS-1], i_self_y});
    assign w_adx = w_dx[COORD_BITS] ? COORD_BITS'(-w_dx) : COORD_BITS'(w_dx);
    assign w_ady = w_dy[COORD_BITS] ? COORD_BITS'(-w_dy) : COORD_BITS'(w_dy);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_dx  <= w_adx;
            r_c_dy  <= w_ady;
            r_c_tag.skip <= i_tag.skip;
            r_c_tag.id   <= i_tag.id;
            r_d_dx2 <= r_c_dx * r_c_dx;
            r_d_dy2 <= r_c_dy * r_c_dy;
            r_d_tag.skip <= r_c_tag.skip;
            r_d_tag.id   <= r_c_tag.id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_tag.vld <= 1'b0;
            r_d_tag.vld <= 1'b0;
        end else if (i_en) begin
            r_c_tag.vld <= i_tag.vld;
            r_d_tag.vld <= r_c_tag.vld;
        end
    end

    assign w_sum = SW'(r_d_dx2) + SW'(r_d_dy2);

    assign o_hit.vld = r_d_tag.vld;
    assign o_hit.hit = r_d_tag.vld && !r_d_tag.skip && (w_sum < SW'(i_r2));
    assign o_hit.id  = r_d_tag.id;
    assign o_busy    = r_c_tag.vld || r_d_tag.vld;

endmodule

`default_nettype wire

>>> hw/rtl/fixed_radius_neighbor_search.sv
// Top level of the fixed-radius neighbor search: control sequencer and result register.
//
// Input channel (i_in_valid / o_in_ready) takes one item per transfer. An update
// (operation 0) writes the x and y of one agent in the transfer cycle and gives no
// result; the block is ready again in the next cycle. A query (operation 1) reads
// the queried agent's position, then scans table entries 0 .. n-1 through the
// single read port of the table memory, one entry per cycle unless the output
// stalls, where n is the smaller of agents_in_use and MAX_AGENTS. Matches leave on
// the output channel (o_out_valid / i_out_ready) in ascending id order; the last
// one carries o_last. A query with no match or an id not below n gives one result
// with o_found low. With the receiver always ready a query holds o_in_ready low
// after its transfer through the self read, the scan, the table read and two
// distance stages, the check that the pipeline is empty and the closing result.
// A held result sits in the output register; while the receiver stalls, the scan
// freezes in place and resumes without loss. The next item is taken while the
// closing result still waits. Reset (i_rst_n low, synchronous) clears the table to
// the origin, sets agents_in_use to 32 and empties the output register.
// i_cfg_we writes agents_in_use; write it only while no query is in flight.
`default_nettype none

module fixed_radius_neighbor_search
    import fnrs_pkg::*;
#(
    parameter int MAX_AGENTS = MAX_AGENTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_W-1:0]        i_cfg_data,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic                    i_operation,
    input  wire logic [ID_W-1:0]         i_agent_id,
    input  wire logic signed [POS_W-1:0] i_pos_x,
    input  wire logic signed [POS_W-1:0] i_pos_y,
    input  wire logic [RAD_W-1:0]        i_radius,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [ID_W-1:0]              o_neighbor_id,
    output logic                         o_found,
    output logic                         o_last
);

    localparam int IW = $clog2(MAX_AGENTS);
    localparam int NW = $clog2(MAX_AGENTS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SELF = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic [CFG_W-1:0]      r_cfg;
    logic [IW-1:0]         r_qidx;
    logic [RAD_W-1:0]      r_radius;
    logic [R2_W-1:0]       r_r2;
    logic [COORD_BITS-1:0] r_self_x;
    logic [COORD_BITS-1:0] r_self_y;
    logic [NW-1:0]         r_iss;
    t_tag                  r_tag_b;
    logic                  r_hold_v;
    logic [ID_W-1:0]       r_hold_id;
    logic                  r_out_v;
    logic [ID_W-1:0]       r_out_id;
    logic                  r_out_found;
    logic                  r_out_last;

    logic [NW-1:0]         w_n;
    logic                  w_in_xfer;
    logic                  w_upd;
    logic                  w_qry;
    logic                  w_qry_ok;
    logic                  w_stall;
    logic                  w_issue;
    logic                  w_rd_en;
    logic [IW-1:0]         w_rd_addr;
    logic [COORD_BITS-1:0] w_rd_x;
    logic [COORD_BITS-1:0] w_rd_y;
    t_hit                  w_hit;
    logic                  w_busy;
    logic                  w_drained;

    always_comb begin
        if (32'(r_cfg) > 32'(MAX_AGENTS)) begin
            w_n = NW'(MAX_AGENTS);
        end else begin
            w_n = NW'(r_cfg);
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_upd      = w_in_xfer && (i_operation == OP_UPDATE)
                      && (32'(i_agent_id) < 32'(MAX_AGENTS));
    assign w_qry      = w_in_xfer && (i_operation == OP_QUERY);
    assign w_qry_ok   = 32'(i_agent_id) < 32'(w_n);

    // Stall everything downstream of the table while a result waits in the output register
    assign w_stall   = r_out_v && !i_out_ready;
    assign w_issue   = (r_state == S_SCAN) && !w_stall && (r_iss < w_n);
    assign w_rd_en   = (w_qry && w_qry_ok) || w_issue;
    assign w_rd_addr = w_issue ? r_iss[IW-1:0] : IW'(i_agent_id);
    assign w_drained = (r_iss == w_n) && !r_tag_b.vld && !w_busy;

    fnrs_table #(
        .MAX_AGENTS (MAX_AGENTS),
        .COORD_BITS (COORD_BITS)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_upd),
        .i_wr_addr (IW'(i_agent_id)),
        .i_wr_x    (COORD_BITS'(i_pos_x)),
        .i_wr_y    (COORD_BITS'(i_pos_y)),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_x    (w_rd_x),
        .o_rd_y    (w_rd_y)
    );

    fnrs_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (!w_stall),
        .i_tag    (r_tag_b),
        .i_rd_x   (w_rd_x),
        .i_rd_y   (w_rd_y),
        .i_self_x (r_self_x),
        .i_self_y (r_self_y),
        .i_r2     (r_r2),
        .o_hit    (w_hit),
        .o_busy   (w_busy)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_qry) begin
                    n_state = w_qry_ok ? S_SELF : S_DONE;
                end
            end
            S_SELF: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (w_drained) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!w_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Payload registers of the query
    always_ff @(posedge i_clk) begin
        if (w_qry) begin
            r_qidx   <= IW'(i_agent_id);
            r_radius <= i_radius;
        end
        if (r_state == S_SELF) begin
            r_self_x <= w_rd_x;
            r_self_y <= w_rd_y;
            r_r2     <= R2_W'(r_radius) * R2_W'(r_radius);
        end
        if (w_issue) begin
            r_tag_b.skip <= (r_iss[IW-1:0] == r_qidx);
            r_tag_b.id   <= ID_W'(r_iss);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= CFG_RESET_AGENTS;
            r_iss       <= '0;
            r_tag_b.vld <= 1'b0;
            r_hold_v    <= 1'b0;
            r_hold_id   <= '0;
            r_out_v     <= 1'b0;
            r_out_id    <= '0;
            r_out_found <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (w_qry) begin
                r_iss <= '0;
            end else if (w_issue) begin
                r_iss <= r_iss + 1'b1;
            end
            if (!w_stall && r_state == S_SCAN) begin
                r_tag_b.vld <= w_issue;
            end

            // Drop the output once transferred; a load below overrides
            if (r_out_v && i_out_ready) begin
                r_out_v <= 1'b0;
            end

            if (!w_stall && w_hit.vld && w_hit.hit) begin
                // A newer match proves the held one is not last: send it on
                if (r_hold_v) begin
                    r_out_v     <= 1'b1;
                    r_out_id    <= r_hold_id;
                    r_out_found <= 1'b1;
                    r_out_last  <= 1'b0;
                end
                r_hold_v  <= 1'b1;
                r_hold_id <= w_hit.id;
            end

            if (!w_stall && r_state == S_DONE) begin
                r_out_v     <= 1'b1;
                r_out_id    <= r_hold_v ? r_hold_id : '0;
                r_out_found <= r_hold_v;
                r_out_last  <= 1'b1;
                r_hold_v    <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_v;
    assign o_neighbor_id = r_out_id;
    assign o_found       = r_out_found;
    assign o_last        = r_out_last;

endmodule

`default_nettype wire

>>> hw/rtl/fnrs_checker.sv
// Port-level checker for the fixed-radius neighbor search, bound to the top level.
`default_nettype none

module fnrs_checker
    import fnrs_pkg::*;
(
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_in_valid,
    input wire logic            o_in_ready,
    input wire logic            i_operation,
    input wire logic            o_out_valid,
    input wire logic            i_out_ready,
    input wire logic [ID_W-1:0] o_neighbor_id,
    input wire logic            o_found,
    input wire logic            o_last
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_neighbor_id) && $stable(o_found) && $stable(o_last))
        else $error("result payload changed while stalled");

    // An empty answer is always the single closing result with id zero
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_last && (o_neighbor_id == '0))
        else $error("empty answer not closing or carries an id");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_operation == OP_QUERY) |=> !o_in_ready)
        else $error("next item taken right after a query transfer");

    a_update_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_operation == OP_UPDATE) |=> o_in_ready)
        else $error("update transfer left the input channel blocked");

endmodule

bind fixed_radius_neighbor_search fnrs_checker u_fnrs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_operation   (i_operation),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_neighbor_id (o_neighbor_id),
    .o_found       (o_found),
    .o_last        (o_last)
);

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the fixed-radius neighbor search block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fnrs_pkg::*;

    localparam int DRAIN_CYCLES = 48;
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_CYCLES = 400_000;
    localparam logic [RAD_W-1:0] RAD_MAX = {RAD_W{1'b1}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};

    typedef struct {
        logic [ID_W-1:0] id;
        logic            found;
        logic            is_last;
    } t_neighbor;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_W-1:0]        cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    op = OP_UPDATE;
    logic [ID_W-1:0]         agent_id = '0;
    logic signed [POS_W-1:0] pos_x = '0;
    logic signed [POS_W-1:0] pos_y = '0;
    logic [RAD_W-1:0]        radius = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [ID_W-1:0]         neighbor_id;
    logic                    found;
    logic                    is_last;

    // Predictor state
    logic signed [POS_W-1:0] x_tab [MAX_AGENTS_DEF];
    logic signed [POS_W-1:0] y_tab [MAX_AGENTS_DEF];
    logic [CFG_W-1:0]        agents_cfg;
    t_neighbor               expected_neighbors [$];

    int  fail_count = 0;
    int  cycle_count = 0;
    int  burst_left = 0;
    bit  steady_sender = 1'b0;
    bit  hold_req = 1'b0;

    fixed_radius_neighbor_search dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_operation   (op),
        .i_agent_id    (agent_id),
        .i_pos_x       (pos_x),
        .i_pos_y       (pos_y),
        .i_radius      (radius),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_neighbor_id (neighbor_id),
        .o_found       (found),
        .o_last        (is_last)
    );

    always #4 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int active_agents();
        return (agents_cfg < MAX_AGENTS_DEF) ? int'(agents_cfg) : MAX_AGENTS_DEF;
    endfunction

    // Work out the neighbors one item yields and queue them in scan order
    task automatic predict_neighbors(input logic o, input logic [ID_W-1:0] id,
                                     input logic signed [POS_W-1:0] px,
                                     input logic signed [POS_W-1:0] py,
                                     input logic [RAD_W-1:0] rad);
        int                n;
        longint            dx;
        longint            dy;
        longint            r2;
        t_neighbor         hits [$];
        t_neighbor         nb;
        n = active_agents();
        if (o == OP_UPDATE) begin
            x_tab[id] = px;
            y_tab[id] = py;
        end else begin
            r2 = longint'(rad) * longint'(rad);
            if (int'(id) < n) begin
                for (int i = 0; i < n; i++) begin
                    if (i != int'(id)) begin
                        dx = longint'(x_tab[i]) - longint'(x_tab[id]);
                        dy = longint'(y_tab[i]) - longint'(y_tab[id]);
                        if (dx*dx + dy*dy < r2) begin
                            nb.id = i[ID_W-1:0];
                            nb.found = 1'b1;
                            nb.is_last = 1'b0;
                            hits.push_back(nb);
                        end
                    end
                end
            end
            if (hits.size() == 0) begin
                nb.id = '0;
                nb.found = 1'b0;
                nb.is_last = 1'b1;
                hits.push_back(nb);
            end else begin
                hits[hits.size()-1].is_last = 1'b1;
            end
            foreach (hits[k]) expected_neighbors.push_back(hits[k]);
        end
    endtask

    // Offer one item, hold it until the transfer, then predict it
    task automatic send_item(input logic o, input logic [ID_W-1:0] id,
                             input logic signed [POS_W-1:0] px,
                             input logic signed [POS_W-1:0] py,
                             input logic [RAD_W-1:0] rad);
        int gap;
        bit taken;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (!steady_sender && $urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 10);
        end
        burst_left--;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        agent_id <= id;
        pos_x    <= px;
        pos_y    <= py;
        radius   <= rad;
        // Inputs are stable between edges, so ready at the falling edge decides the transfer
        do begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end while (!taken);
        predict_neighbors(o, id, px, py, rad);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_neighbors.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_agents(input logic [CFG_W-1:0] count);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= count;
        @(posedge clk);
        cfg_we   <= 1'b0;
        agents_cfg = count;
    endtask

    task automatic query(input logic [ID_W-1:0] id, input logic [RAD_W-1:0] rad);
        send_item(OP_QUERY, id, POS_W'($urandom), POS_W'($urandom), rad);
    endtask

    task automatic place(input logic [ID_W-1:0] id, input logic signed [POS_W-1:0] px,
                         input logic signed [POS_W-1:0] py);
        send_item(OP_UPDATE, id, px, py, RAD_W'($urandom));
    endtask

    function automatic logic signed [POS_W-1:0] coord_near(
            input logic signed [POS_W-1:0] c, input int k);
        if (k >= POS_W - 1)
            return POS_W'($urandom);
        return POS_W'(int'(c) + int'($urandom_range(0, 2**(k+1))) - 2**k);
    endfunction

    task automatic report_mismatch(input string what, input t_neighbor want);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t %s: expected id=%0d found=%0b last=%0b, got id=%0d found=%0b last=%0b",
                     $realtime, what, want.id, want.found, want.is_last,
                     neighbor_id, found, is_last);
    endtask

    // Compare every output transfer with the oldest expectation
    initial begin : result_check
        t_neighbor want;
        t_neighbor none;
        none.id = '0;
        none.found = 1'b0;
        none.is_last = 1'b0;
        forever begin
            @(negedge clk);
            if (rst_n && out_valid === 1'b1 && out_ready) begin
                if (expected_neighbors.size() == 0) begin
                    report_mismatch("unexpected result", none);
                end else begin
                    want = expected_neighbors.pop_front();
                    if (neighbor_id !== want.id || found !== want.found
                            || is_last !== want.is_last)
                        report_mismatch("result mismatch", want);
                end
            end
        end
    end

    // Receiver: random stall segments, plus a long hold-off on request
    initial begin : receiver
        int seg;
        int mode;
        int held;
        seg = 0;
        mode = 0;
        held = 0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                held++;
                if (held == HOLD_CYCLES) begin
                    held = 0;
                    hold_req = 1'b0;
                end
            end else begin
                if (seg == 0) begin
                    seg = $urandom_range(4, 40);
                    mode = $urandom_range(0, 2);
                end
                seg--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    default: out_ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // Cleared table: everything sits at the origin
    task automatic test_reset_table();
        query(0, 1);
        query(31, 0);
        query(17, RAD_MAX);
    endtask

    task automatic test_extremes();
        place(1, POS_MIN, POS_MAX);
        place(2, POS_MAX, POS_MIN);
        place(3, POS_MAX, POS_MAX);
        place(4, POS_MIN, POS_MIN);
        query(1, RAD_MAX);
        query(4, RAD_MAX);
        query(3, 1);
        // 3-4-5 triangle: exactly on the radius does not match, one step past does
        place(5, 24'sd768, 24'sd1024);
        query(6, 23'd1280);
        query(6, 23'd1281);
        place(0, -24'sd1, -24'sd1);
        query(7, 23'd1);
        query(0, 23'd2);
    endtask

    task automatic test_agent_count();
        set_agents(0);
        query(0, RAD_MAX);
        set_agents(1);
        query(0, RAD_MAX);
        query(1, RAD_MAX);
        place(20, 24'sd256, -24'sd256);
        set_agents(2);
        query(0, RAD_MAX);
        query(2, RAD_MAX);
        set_agents(33);
        query(20, 23'd512);
        set_agents(63);
        query(31, RAD_MAX);
        set_agents(CFG_RESET_AGENTS);
        query(20, RAD_MAX);
    endtask

    // Stall the output long enough to back up the input, then pause until drained
    task automatic test_backpressure();
        steady_sender = 1'b1;
        hold_req = 1'b1;
        repeat (8) query(ID_W'($urandom_range(6, 31)), RAD_MAX);
        steady_sender = 1'b0;
        wait_drained();
    endtask

    task automatic test_random();
        int                      n;
        int                      k;
        logic [CFG_W-1:0]        count;
        logic signed [POS_W-1:0] cx;
        logic signed [POS_W-1:0] cy;
        logic [ID_W-1:0]         id;
        logic [RAD_W-1:0]        rad;
        for (int phase = 0; phase < 5; phase++) begin
            if ($urandom_range(0, 9) == 0)
                count = ($urandom_range(0, 1) != 0) ? 6'd33 : 6'd63;
            else
                count = CFG_W'($urandom_range(1, 32));
            set_agents(count);
            n = active_agents();
            k = ($urandom_range(0, 2) == 0) ? POS_W - 1 : $urandom_range(2, 18);
            cx = POS_W'($urandom);
            cy = POS_W'($urandom);
            steady_sender = ($urandom_range(0, 2) == 0);
            repeat (18) begin
                if ($urandom_range(0, 3) != 0)
                    id = ID_W'($urandom_range(0, n - 1));
                else
                    id = ID_W'($urandom_range(0, 31));
                if ($urandom_range(0, 9) < 4) begin
                    place(id, coord_near(cx, k), coord_near(cy, k));
                end else begin
                    if (k >= POS_W - 1)
                        rad = RAD_W'($urandom);
                    else
                        rad = RAD_W'($urandom_range(0, 2**(k+1)));
                    query(id, rad);
                end
            end
            steady_sender = 1'b0;
        end
    endtask

    initial begin
        for (int i = 0; i < MAX_AGENTS_DEF; i++) begin
            x_tab[i] = '0;
            y_tab[i] = '0;
        end
        agents_cfg = CFG_RESET_AGENTS;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_table();
        test_extremes();
        test_agent_count();
        test_backpressure();
        test_random();
        wait_drained();
        fail_count += expected_neighbors.size();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
